// ===== src/wcf_pkg.sv =====
// Shared types, codes and sizing helpers of the wheel command frame parser.
package wcf_pkg;

	// Default number of motors described by one frame.
	localparam int MOTOR_COUNT_DEF = 4;

	// Entries of the queue between the parsing front and the result back.
	localparam int QUEUE_DEPTH = 2;

	// Valid action codes.
	localparam logic [7:0] ACTION_ONE   = 8'h01;
	localparam logic [7:0] ACTION_TWO   = 8'h02;
	localparam logic [7:0] ACTION_THREE = 8'h03;

	// Outcome reported for each received byte.
	typedef enum logic [1:0] {
		ST_MORE  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// Position of a byte inside one motor's five-byte group.
	typedef enum logic [2:0] {
		SL_ACTION   = 3'd0,
		SL_SPEED_HI = 3'd1,
		SL_SPEED_LO = 3'd2,
		SL_TICK_HI  = 3'd3,
		SL_TICK_LO  = 3'd4
	} slot_t;

	// Fields collected for one motor.
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] speed;
		logic [15:0] ticks;
	} motor_rec_t;

	// Request carried on the byte input channel.
	typedef struct packed {
		logic [7:0] data_byte;
	} byte_req_t;

	// Request carried on the result output channel.
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  motor_number;
		logic [1:0]  wheel_action;
		logic [15:0] wheel_speed;
		logic [15:0] tick_limit;
		logic [7:0]  frame_checksum;
		logic        last_result;
	} result_t;

	// Width of one queued job: status, checksum and one record per motor.
	function automatic int job_width(input int mc);
		return 10 + mc * $bits(motor_rec_t);
	endfunction

endpackage

// ===== src/wcf_stream_if.sv =====
// Valid/ready stream channel used for the byte input and the result output.
interface wcf_stream_if #(
	parameter type payload_t = wcf_pkg::byte_req_t
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/wcf_front.sv =====
// Byte parser: tracks frame position and checksum, collects motor fields, queues jobs.
module wcf_front #(
	parameter int MOTOR_COUNT = wcf_pkg::MOTOR_COUNT_DEF,
	parameter int JOB_W       = wcf_pkg::job_width(MOTOR_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	wcf_stream_if.sink       rx,
	output logic             push_valid,
	input  logic             push_ready,
	output logic [JOB_W-1:0] push_data
);

	localparam int MCNT_W = $clog2(MOTOR_COUNT + 1);
	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef struct packed {
		logic [1:0]                              status;
		logic [7:0]                              checksum;
		wcf_pkg::motor_rec_t [MOTOR_COUNT-1:0]   recs;
	} job_t;

	logic [MCNT_W-1:0]                     motor_q;
	wcf_pkg::slot_t                        slot_q;
	logic [6:0]                            sum_q;
	wcf_pkg::motor_rec_t [MOTOR_COUNT-1:0] recs_q;

	logic              accept;
	logic              at_end;
	logic              action_ok;
	logic              bad_action;
	logic [6:0]        sum_nx;
	logic [7:0]        b;
	logic [MIDX_W-1:0] widx;
	job_t              job;

	always_comb begin
		b          = rx.payload.data_byte;
		accept     = rx.valid && push_ready;
		at_end     = (motor_q == MCNT_W'(MOTOR_COUNT));
		sum_nx     = sum_q + b[6:0];
		widx       = motor_q[MIDX_W-1:0];
		action_ok  = (b == wcf_pkg::ACTION_ONE) || (b == wcf_pkg::ACTION_TWO) ||
			(b == wcf_pkg::ACTION_THREE);
		bad_action = (slot_q == wcf_pkg::SL_ACTION) && !action_ok;
	end

	always_comb begin
		job.checksum = b;
		job.recs     = recs_q;
		if (at_end) begin
			job.status = (sum_nx == 7'd0) ? wcf_pkg::ST_DONE : wcf_pkg::ST_ERROR;
		end else if (bad_action) begin
			job.status = wcf_pkg::ST_ERROR;
		end else begin
			job.status = wcf_pkg::ST_MORE;
		end
	end

	assign rx.ready   = push_ready;
	assign push_valid = accept;
	assign push_data  = JOB_W'(job);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q <= '0;
			slot_q  <= wcf_pkg::SL_ACTION;
			sum_q   <= '0;
		end else if (accept) begin
			if (at_end || bad_action) begin
				motor_q <= '0;
				slot_q  <= wcf_pkg::SL_ACTION;
				sum_q   <= '0;
			end else begin
				sum_q <= sum_nx;
				if (slot_q == wcf_pkg::SL_TICK_LO) begin
					slot_q  <= wcf_pkg::SL_ACTION;
					motor_q <= motor_q + MCNT_W'(1);
				end else begin
					slot_q <= wcf_pkg::slot_t'(slot_q + 3'd1);
				end
			end
		end
	end

	// Motor records hold no reset; each entry is written before a frame completes.
	always_ff @(posedge clk) begin
		if (accept && !at_end) begin
			unique case (slot_q)
				wcf_pkg::SL_ACTION: begin
					if (action_ok) recs_q[widx].action <= b[1:0];
				end
				wcf_pkg::SL_SPEED_HI: recs_q[widx].speed[15:8] <= b;
				wcf_pkg::SL_SPEED_LO: recs_q[widx].speed[7:0]  <= b;
				wcf_pkg::SL_TICK_HI:  recs_q[widx].ticks[15:8] <= b;
				wcf_pkg::SL_TICK_LO:  recs_q[widx].ticks[7:0]  <= b;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/wcf_queue.sv =====
// Short first-in first-out queue of parsed jobs between front and back.
module wcf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = wcf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_q] <= push_data;
	end

endmodule

// ===== src/wcf_back.sv =====
// Result sequencer: holds the current job and emits its one or per-motor results.
module wcf_back #(
	parameter int MOTOR_COUNT = wcf_pkg::MOTOR_COUNT_DEF,
	parameter int JOB_W       = wcf_pkg::job_width(MOTOR_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [JOB_W-1:0] pop_data,
	wcf_stream_if.source     res
);

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef struct packed {
		logic [1:0]                              status;
		logic [7:0]                              checksum;
		wcf_pkg::motor_rec_t [MOTOR_COUNT-1:0]   recs;
	} job_t;

	job_t              cur_q;
	logic              cur_v_q;
	logic [MIDX_W-1:0] k_q;

	logic                is_done;
	logic                last;
	logic                finishing;
	wcf_pkg::motor_rec_t rec;
	wcf_pkg::result_t    r;

	always_comb begin
		is_done   = (cur_q.status == wcf_pkg::ST_DONE);
		last      = (k_q == MIDX_W'(MOTOR_COUNT - 1));
		finishing = !is_done || last;
		rec       = cur_q.recs[k_q];
		pop_ready = !cur_v_q || (res.ready && finishing);
	end

	always_comb begin
		r.status = cur_q.status;
		if (is_done) begin
			r.motor_number   = 2'(k_q);
			r.wheel_action   = rec.action;
			r.wheel_speed    = rec.speed;
			r.tick_limit     = rec.ticks;
			r.frame_checksum = cur_q.checksum;
			r.last_result    = last;
		end else begin
			r.motor_number   = '0;
			r.wheel_action   = '0;
			r.wheel_speed    = '0;
			r.tick_limit     = '0;
			r.frame_checksum = '0;
			r.last_result    = 1'b1;
		end
	end

	assign res.valid   = cur_v_q;
	assign res.payload = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			k_q     <= '0;
		end else if (pop_ready) begin
			cur_v_q <= pop_valid;
			k_q     <= '0;
		end else if (res.ready) begin
			k_q <= k_q + MIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready) cur_q <= job_t'(pop_data);
	end

endmodule

// ===== src/wheel_command_frame_parser.sv =====
// Top level of the wheel command frame parser: front, job queue and result back.
//
// Usage: bytes of a command frame arrive one request at a time on rx. A frame
// holds, for each motor, an action byte (1, 2 or 3), a speed high and low byte
// and a tick limit high and low byte, then one checksum byte; the frame is
// good when all its bytes sum to zero modulo 128.
// Every accepted byte produces results on res. A byte that leaves the frame
// open gives one request with status "need more"; a bad action byte or a bad
// checksum gives one request with status "error" and restarts the frame. A
// good checksum gives MOTOR_COUNT requests, motor 0 first, with last_result
// set on the final one.
// An accepted byte is written into the job queue and then loaded into the back
// register before its first result is valid on res. Throughput: one byte per
// cycle while the bytes give single results and res is ready; a completed frame
// occupies the result port for MOTOR_COUNT results, the back stepping one motor
// per cycle while res is ready.
// A two-entry job queue sits between the parser and the sequencer, so bytes
// keep being taken while results wait. When res is stalled the queue fills
// and rx.ready drops; nothing is lost or reordered.
// Reset clears the frame position, the checksum and the queue; the motor
// records are loaded by each frame before use and need no reset.
module wheel_command_frame_parser #(
	parameter int MOTOR_COUNT = wcf_pkg::MOTOR_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	wcf_stream_if.sink   rx,
	wcf_stream_if.source res
);

	localparam int JOB_W = wcf_pkg::job_width(MOTOR_COUNT);

	logic             push_valid;
	logic             push_ready;
	logic [JOB_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [JOB_W-1:0] pop_data;

	// The front classifies each byte and turns it into one queued job.
	wcf_front #(
		.MOTOR_COUNT (MOTOR_COUNT),
		.JOB_W       (JOB_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Jobs carry a copy of the motor records, so the front may start the next
	// frame while the back is still emitting the previous one.
	wcf_queue #(
		.WIDTH (JOB_W),
		.DEPTH (wcf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back holds one job and steps through its results.
	wcf_back #(
		.MOTOR_COUNT (MOTOR_COUNT),
		.JOB_W       (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res       (res)
	);

	// A queued job reaches the result port in the next cycle when it is idle.
	a_job_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !res.valid) |=> res.valid)
		else $error("queued job did not reach the result port");

	// Results of a completed frame come in consecutive motor order.
	a_motor_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.payload.last_result) |=>
		(res.valid && (res.payload.motor_number == $past(res.payload.motor_number) + 2'd1)))
		else $error("frame results out of motor order");

	// The input is only held off while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> res.valid)
		else $error("input stalled with no result pending");

endmodule
